/* rtl/orb_pkg.sv */
// Shared constants, codes and helper functions of the overwriting ring buffer.
// Used by orb_ctrl, orb_datapath and overwriting_ring_buffer; no dependencies.
package orb_pkg;

    localparam int DEPTH      = 64;
    localparam int ELEM_BYTES = 4;
    localparam int DATA_W     = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CAP_W      = 7;
    localparam int OFF_W      = 6;
    localparam int CNT_W      = 6;

    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [DATA_W-1:0] ELEM_MASK =
        (ELEM_BYTES >= 4) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << (8 * ELEM_BYTES)) - 64'd1);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Out-of-range capacity values are clamped to the legal range.
    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] c;
        c = cap;
        if (c < CAP_MIN) c = CAP_MIN;
        if (c > CAP_MAX) c = CAP_MAX;
        return c;
    endfunction

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p,
                                                  input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] q;
        q = CAP_W'(p) + CAP_W'(1);
        return (q >= cap) ? '0 : q[PTR_W-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] occupancy(input logic [PTR_W-1:0] s,
                                                   input logic [PTR_W-1:0] e,
                                                   input logic [CAP_W-1:0] cap);
        if (e >= s) return CAP_W'(e) - CAP_W'(s);
        return cap - (CAP_W'(s) - CAP_W'(e));
    endfunction

endpackage

/* rtl/overwriting_ring_buffer.sv */
// Top level of the overwriting ring buffer.
// Instantiates orb_ctrl and orb_datapath; depends on orb_pkg.
//
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_stall) with an
//   operation code (push, pop, read at offset, clear), push data and a read
//   offset. Each request yields exactly one result on the output channel
//   (o_out_valid / i_out_stall) carrying read data, slot, count and flags.
//   A request is taken when valid is high and stall is low at a clock edge.
//   The result is presented in the cycle after the request is taken.
//   A new request is not taken until the result of the last one is taken;
//   the sequencer holds a single request in flight, and the element memory
//   read for a read request completes in the cycle of acceptance.
//   When the receiver stalls, the result is held unchanged and new requests
//   are stalled until it is taken.
//   Reset (i_rst_n low, synchronous) empties the buffer and sets capacity to
//   64. The memory is not cleared; only entries written by a push are ever
//   read. Writing the capacity register (i_cfg_wr_en) also empties the
//   buffer; write it only while no request is outstanding.
module overwriting_ring_buffer
    import orb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic [OFF_W-1:0]  i_offset,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic [PTR_W-1:0]  o_slot,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_is_full,
    output logic              o_is_empty,
    output logic              o_pop_done,
    output logic              o_overwrote,
    output logic              o_bad_offset,
    input  logic              i_cfg_wr_en,
    input  logic [CAP_W-1:0]  i_cfg_wr_data
);

    logic exec;

    // The sequencer decides when a request executes; the datapath does the work.
    orb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_exec      (exec)
    );

    orb_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_exec        (exec),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_operation   (i_operation),
        .i_push_data   (i_push_data),
        .i_offset      (i_offset),
        .o_read_data   (o_read_data),
        .o_slot        (o_slot),
        .o_count       (o_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty),
        .o_pop_done    (o_pop_done),
        .o_overwrote   (o_overwrote),
        .o_bad_offset  (o_bad_offset)
    );

endmodule

/* rtl/orb_ctrl.sv */
// Request sequencer of the overwriting ring buffer: takes one request at a time
// and holds its result until the receiver takes it. Depends on orb_pkg.
module orb_ctrl
    import orb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output logic o_exec
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_HOLD);
    assign o_exec      = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_HOLD;
            S_HOLD: if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_exec_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_exec |-> !o_out_valid) else $error("request executed while a result is pending");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_exec |=> o_out_valid) else $error("executed request produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && !o_exec) |=> !o_out_valid) else $error("result without request");

endmodule

/* rtl/orb_datapath.sv */
// Datapath of the overwriting ring buffer: pointers, capacity register,
// element memory and result registers. Depends on orb_pkg.
module orb_datapath
    import orb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_exec,
    input  logic              i_cfg_wr_en,
    input  logic [CAP_W-1:0]  i_cfg_wr_data,
    input  logic [1:0]        i_operation,
    input  logic [DATA_W-1:0] i_push_data,
    input  logic [OFF_W-1:0]  i_offset,
    output logic [DATA_W-1:0] o_read_data,
    output logic [PTR_W-1:0]  o_slot,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_is_full,
    output logic              o_is_empty,
    output logic              o_pop_done,
    output logic              o_overwrote,
    output logic              o_bad_offset
);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0] r_cap;
    logic [PTR_W-1:0] r_start;
    logic [PTR_W-1:0] r_end;
    logic [PTR_W-1:0] n_start;
    logic [PTR_W-1:0] n_end;

    logic [DATA_W-1:0] r_mem_q;
    logic              r_rd_good;
    logic [PTR_W-1:0]  r_slot;
    logic [CNT_W-1:0]  r_count;
    logic              r_full;
    logic              r_empty;
    logic              r_pop_done;
    logic              r_overwrote;
    logic              r_bad;

    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] cnt_now;
    logic [CAP_W-1:0] cnt_next;
    logic [CAP_W-1:0] rd_sum;
    logic [PTR_W-1:0] rd_addr;
    logic             is_push;
    logic             is_read;
    logic             full_now;
    logic             off_bad;
    logic [PTR_W-1:0] slot_sel;
    logic             popped;

    assign cap      = eff_cap(r_cap);
    assign cnt_now  = occupancy(r_start, r_end, cap);
    assign full_now = (cnt_now + CAP_W'(1)) == cap;
    assign is_push  = (t_op'(i_operation) == OP_PUSH);
    assign is_read  = (t_op'(i_operation) == OP_READ);
    assign off_bad  = (CAP_W'(i_offset) >= cnt_now);
    assign rd_sum   = CAP_W'(r_start) + CAP_W'(i_offset);
    assign rd_addr  = (rd_sum >= cap) ? PTR_W'(rd_sum - cap) : rd_sum[PTR_W-1:0];
    assign popped   = (t_op'(i_operation) == OP_POP) && (r_start != r_end);

    always_comb begin
        n_start  = r_start;
        n_end    = r_end;
        slot_sel = '0;
        unique case (t_op'(i_operation))
            OP_PUSH: begin
                slot_sel = r_end;
                n_end    = wrap_inc(r_end, cap);
                if (full_now) n_start = wrap_inc(r_start, cap);
            end
            OP_POP: begin
                if (popped) n_start = wrap_inc(r_start, cap);
            end
            OP_READ: begin
                if (!off_bad) slot_sel = rd_addr;
            end
            OP_CLEAR: begin
                n_start = '0;
                n_end   = '0;
            end
            default: begin
                n_start = r_start;
            end
        endcase
    end

    assign cnt_next = occupancy(n_start, n_end, cap);

    // Control state: capacity and pointers. A capacity write empties the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_start <= '0;
            r_end   <= '0;
        end else if (i_cfg_wr_en) begin
            r_cap   <= i_cfg_wr_data;
            r_start <= '0;
            r_end   <= '0;
        end else if (i_exec) begin
            r_start <= n_start;
            r_end   <= n_end;
        end
    end

    // Element memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_exec && is_push) begin
            mem[r_end] <= i_push_data & ELEM_MASK;
        end
        if (i_exec && is_read) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_exec) begin
            r_rd_good   <= is_read && !off_bad;
            r_slot      <= slot_sel;
            r_count     <= cnt_next[CNT_W-1:0];
            r_full      <= (cnt_next + CAP_W'(1)) == cap;
            r_empty     <= (n_start == n_end);
            r_pop_done  <= popped;
            r_overwrote <= is_push && full_now;
            r_bad       <= is_read && off_bad;
        end
    end

    assign o_read_data  = r_rd_good ? r_mem_q : '0;
    assign o_slot       = r_slot;
    assign o_count      = r_count;
    assign o_is_full    = r_full;
    assign o_is_empty   = r_empty;
    assign o_pop_done   = r_pop_done;
    assign o_overwrote  = r_overwrote;
    assign o_bad_offset = r_bad;

    a_start_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAP_W'(r_start) < cap) else $error("start pointer beyond capacity");

    a_end_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CAP_W'(r_end) < cap) else $error("end pointer beyond capacity");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_exec |=> (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the overwriting ring buffer: a directed table, then
// random phases across many capacity settings. Depends on orb_pkg and the RTL only.
module testbench;
    import orb_pkg::*;

    // One result as the block reports it, in port order.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [PTR_W-1:0]  slot;
        logic [CNT_W-1:0]  count;
        logic              is_full;
        logic              is_empty;
        logic              pop_done;
        logic              overwrote;
        logic              bad_offset;
    } ring_result_t;

    // One row of the directed table: either a capacity write or a request.
    // When typed is set, res holds an expected result written out by hand.
    typedef struct packed {
        bit                is_cfg;
        logic [CAP_W-1:0]  cap;
        t_op               op;
        logic [DATA_W-1:0] data;
        logic [OFF_W-1:0]  off;
        bit                typed;
        ring_result_t      res;
    } script_row_t;

    // Operation mixes of the random phases and receiver stall styles.
    typedef enum {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;
    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation   = OP_PUSH;
    logic [DATA_W-1:0] i_push_data   = '0;
    logic [OFF_W-1:0]  i_offset      = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic [PTR_W-1:0]  o_slot;
    logic [CNT_W-1:0]  o_count;
    logic              o_is_full;
    logic              o_is_empty;
    logic              o_pop_done;
    logic              o_overwrote;
    logic              o_bad_offset;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]  i_cfg_wr_data = '0;

    overwriting_ring_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_push_data   (i_push_data),
        .i_offset      (i_offset),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_slot        (o_slot),
        .o_count       (o_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty),
        .o_pop_done    (o_pop_done),
        .o_overwrote   (o_overwrote),
        .o_bad_offset  (o_bad_offset),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // 20 time unit clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the buffer. It holds its own storage, pointers and
    // capacity register and is advanced once for every accepted request.
    // Elements are 32 bits wide, so a push stores its data unmasked.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] ring_mem [DEPTH];
    int unsigned       oldest    = 0;
    int unsigned       next_free = 0;
    logic [CAP_W-1:0]  cap_reg   = CAP_RESET;

    // Expected results in request order, oldest first.
    ring_result_t results_due[$];

    int unsigned errors      = 0;
    int unsigned n_requests  = 0;
    int unsigned n_overwrite = 0;
    int unsigned n_popped    = 0;
    int unsigned n_bad_read  = 0;
    int unsigned n_settings  = 0;
    int unsigned deepest     = 0;
    int unsigned burst_left  = 0;

    // The register accepts any 7-bit value; the buffer clamps it to 2..DEPTH.
    function automatic int unsigned cap_in_use();
        if (cap_reg < 2) return 2;
        if (cap_reg > DEPTH) return DEPTH;
        return cap_reg;
    endfunction

    function automatic int unsigned held(int unsigned cap);
        if (next_free >= oldest) return next_free - oldest;
        return cap - (oldest - next_free);
    endfunction

    function automatic int unsigned step_ptr(int unsigned p, int unsigned cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    // Applies one request to the shadow buffer and returns the result the
    // block must report for it.
    function automatic ring_result_t apply_request(t_op op, logic [DATA_W-1:0] d,
                                                   logic [OFF_W-1:0] off);
        int unsigned  cap;
        int unsigned  n;
        int unsigned  pos;
        ring_result_t r;
        cap = cap_in_use();
        r   = '0;
        case (op)
            OP_PUSH: begin
                // A full buffer makes room by dropping its oldest element.
                r.overwrote = (held(cap) + 1 == cap);
                r.slot      = PTR_W'(next_free);
                ring_mem[next_free] = d;
                next_free = step_ptr(next_free, cap);
                if (r.overwrote) oldest = step_ptr(oldest, cap);
            end
            OP_POP: begin
                if (oldest != next_free) begin
                    oldest     = step_ptr(oldest, cap);
                    r.pop_done = 1'b1;
                end
            end
            OP_READ: begin
                // Offsets at or past the count are rejected and read nothing.
                n = held(cap);
                if (off >= n) begin
                    r.bad_offset = 1'b1;
                end else begin
                    pos = oldest + off;
                    if (pos >= cap) pos -= cap;
                    r.slot      = PTR_W'(pos);
                    r.read_data = ring_mem[pos];
                end
            end
            OP_CLEAR: begin
                oldest    = 0;
                next_free = 0;
            end
        endcase
        n = held(cap);
        r.count    = CNT_W'(n);
        r.is_full  = (n + 1 == cap);
        r.is_empty = (oldest == next_free);
        return r;
    endfunction

    function automatic ring_result_t outcome(logic [DATA_W-1:0] rd, int unsigned slot,
                                             int unsigned cnt, bit full, bit empty,
                                             bit popd, bit ovr, bit bad);
        ring_result_t r;
        r.read_data  = rd;
        r.slot       = PTR_W'(slot);
        r.count      = CNT_W'(cnt);
        r.is_full    = full;
        r.is_empty   = empty;
        r.pop_done   = popd;
        r.overwrote  = ovr;
        r.bad_offset = bad;
        return r;
    endfunction

    function automatic script_row_t step_row(t_op op, logic [DATA_W-1:0] d,
                                             logic [OFF_W-1:0] off, bit typed,
                                             ring_result_t res);
        script_row_t row;
        row       = '0;
        row.op    = op;
        row.data  = d;
        row.off   = off;
        row.typed = typed;
        row.res   = res;
        return row;
    endfunction

    function automatic script_row_t cfg_row(logic [CAP_W-1:0] cap);
        script_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cap    = cap;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Request side. The sender works in bursts: a burst of random length
    // keeps valid high back to back, and between bursts valid drops for a
    // random gap (sometimes none at all). A request stays on the port,
    // unchanged, until the block takes it.
    // ------------------------------------------------------------------
    task automatic send_request(input t_op op, input logic [DATA_W-1:0] d,
                                input logic [OFF_W-1:0] off, input bit typed,
                                input ring_result_t typed_res);
        int unsigned  gap;
        ring_result_t r;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_push_data <= d;
        i_offset    <= off;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // Taken at this edge: advance the shadow buffer and queue the result.
        r = apply_request(op, d, off);
        results_due.push_back(typed ? typed_res : r);
        burst_left--;
        n_requests++;
        if (r.overwrote) n_overwrite++;
        if (r.pop_done) n_popped++;
        if (r.bad_offset) n_bad_read++;
        if (r.count > deepest) deepest = r.count;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // A capacity write also empties the buffer, so it is only done with the
    // block idle.
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_reg    = v;
        oldest     = 0;
        next_free  = 0;
        burst_left = 0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Result side. The receiver stalls in stretches of random length, each
    // with a style of its own: never, now and then, mostly, or in short
    // regular runs.
    // ------------------------------------------------------------------
    rx_mode_t    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(3));
            rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_out_stall <= 1'b0;
            RX_LIGHT:  i_out_stall <= ($urandom_range(3) == 0);
            RX_HEAVY:  i_out_stall <= ($urandom_range(3) != 0);
            RX_BURSTY: i_out_stall <= (rx_left % 4 < 2);
        endcase
    end

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Every result taken from the block is checked against the oldest
    // expectation, field by field.
    ring_result_t want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
            end else begin
                want_res = results_due.pop_front();
                compare_field("read_data",  want_res.read_data,  o_read_data);
                compare_field("slot",       want_res.slot,       o_slot);
                compare_field("count",      want_res.count,      o_count);
                compare_field("is_full",    want_res.is_full,    o_is_full);
                compare_field("is_empty",   want_res.is_empty,   o_is_empty);
                compare_field("pop_done",   want_res.pop_done,   o_pop_done);
                compare_field("overwrote",  want_res.overwrote,  o_overwrote);
                compare_field("bad_offset", want_res.bad_offset, o_bad_offset);
            end
        end
    end

    // Hard limit on the run; a correct run finishes far earlier.
    initial begin
        #4000000;
        $display("%0t: run limit reached, %0d results outstanding", $time,
                 results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, final check.
    // ------------------------------------------------------------------
    initial begin
        script_row_t       script[$];
        logic [CAP_W-1:0]  phase_caps[$];
        mix_t              mix;
        t_op               op;
        logic [DATA_W-1:0] d;
        logic [OFF_W-1:0]  off;
        int unsigned       ph;
        int unsigned       k;
        int unsigned       roll;
        int unsigned       push_w;
        int unsigned       pop_w;
        int unsigned       read_w;
        int unsigned       n_items;
        int unsigned       cur;

        // Directed table. At the reset capacity of 64: pop and reads on an
        // empty buffer, pushes of all-ones and all-zeros, good and rejected
        // reads, a pop and a clear.
        script.push_back(step_row(OP_POP,   '0,            0,  1, outcome(0, 0, 0, 0, 1, 0, 0, 0)));
        script.push_back(step_row(OP_READ,  '1,            0,  1, outcome(0, 0, 0, 0, 1, 0, 0, 1)));
        script.push_back(step_row(OP_READ,  '0,            63, 1, outcome(0, 0, 0, 0, 1, 0, 0, 1)));
        script.push_back(step_row(OP_PUSH,  '1,            63, 1, outcome(0, 0, 1, 0, 0, 0, 0, 0)));
        script.push_back(step_row(OP_PUSH,  '0,            0,  1, outcome(0, 1, 2, 0, 0, 0, 0, 0)));
        script.push_back(step_row(OP_READ,  '0,            0,  1, outcome('1, 0, 2, 0, 0, 0, 0, 0)));
        script.push_back(step_row(OP_READ,  '0,            1,  1, outcome(0, 1, 2, 0, 0, 0, 0, 0)));
        script.push_back(step_row(OP_READ,  '0,            2,  1, outcome(0, 0, 2, 0, 0, 0, 0, 1)));
        script.push_back(step_row(OP_POP,   '0,            0,  1, outcome(0, 0, 1, 0, 0, 1, 0, 0)));
        script.push_back(step_row(OP_READ,  '0,            0,  1, outcome(0, 1, 1, 0, 0, 0, 0, 0)));
        script.push_back(step_row(OP_CLEAR, '1,            63, 1, outcome(0, 0, 0, 0, 1, 0, 0, 0)));
        // Smallest capacity: one element fits, so every further push
        // overwrites and the pointers wrap on every second step.
        script.push_back(cfg_row(7'd2));
        script.push_back(step_row(OP_PUSH,  32'h1,         0,  1, outcome(0, 0, 1, 1, 0, 0, 0, 0)));
        script.push_back(step_row(OP_PUSH,  32'h2,         0,  1, outcome(0, 1, 1, 1, 0, 0, 1, 0)));
        script.push_back(step_row(OP_READ,  '0,            0,  1, outcome(2, 1, 1, 1, 0, 0, 0, 0)));
        script.push_back(step_row(OP_PUSH,  32'h3,         0,  1, outcome(0, 0, 1, 1, 0, 0, 1, 0)));
        script.push_back(step_row(OP_POP,   '0,            0,  1, outcome(0, 0, 0, 0, 1, 1, 0, 0)));
        script.push_back(step_row(OP_POP,   '0,            0,  1, outcome(0, 0, 0, 0, 1, 0, 0, 0)));
        // A capacity of zero is clamped up to two.
        script.push_back(cfg_row(7'd0));
        script.push_back(step_row(OP_PUSH,  32'hDEADBEEF,  0,  1, outcome(0, 0, 1, 1, 0, 0, 0, 0)));
        script.push_back(step_row(OP_PUSH,  32'h5,         0,  1, outcome(0, 1, 1, 1, 0, 0, 1, 0)));
        // The largest register value is clamped down to the depth, and the
        // write empties the buffer.
        script.push_back(cfg_row(7'd127));
        script.push_back(step_row(OP_READ,  '0,            0,  1, outcome(0, 0, 0, 0, 1, 0, 0, 1)));
        script.push_back(step_row(OP_PUSH,  32'h80000001,  0,  1, outcome(0, 0, 1, 0, 0, 0, 0, 0)));
        script.push_back(step_row(OP_READ,  '0,            1,  1, outcome(0, 0, 1, 0, 0, 0, 0, 1)));
        script.push_back(step_row(OP_PUSH,  $urandom(),    0,  0, '0));
        script.push_back(step_row(OP_READ,  '0,            1,  0, '0));
        script.push_back(step_row(OP_CLEAR, '0,            0,  0, '0));

        // Capacities of the random phases. Most large ones sit on fill-heavy
        // phases so that the buffer runs full and overwrites.
        phase_caps = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd3, 7'd5, 7'd65, 7'd17, 7'd1,
                       7'd33, 7'd8, 7'd64, 7'd64};
        phase_caps[12] = CAP_W'($urandom_range(2, 64));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                write_capacity(script[i].cap);
            end else begin
                send_request(script[i].op, script[i].data, script[i].off,
                             script[i].typed, script[i].res);
            end
        end

        for (ph = 0; ph < phase_caps.size(); ph++) begin
            write_capacity(phase_caps[ph]);
            mix = mix_t'(ph % 3);
            case (mix)
                MIX_FILL: begin
                    push_w = 60; pop_w = 10; read_w = 29;
                end
                MIX_EVEN: begin
                    push_w = 40; pop_w = 25; read_w = 32;
                end
                MIX_DRAIN: begin
                    push_w = 28; pop_w = 38; read_w = 31;
                end
            endcase
            n_items = (cap_in_use() >= 32) ? 180 : 90;
            for (k = 0; k < n_items; k++) begin
                // Unused fields carry random noise on every request.
                d    = $urandom();
                off  = OFF_W'($urandom_range(63));
                roll = $urandom_range(99);
                if (roll < push_w) begin
                    op = OP_PUSH;
                    if ($urandom_range(9) == 0) d = $urandom_range(1) ? '1 : '0;
                end else if (roll < push_w + pop_w) begin
                    op = OP_POP;
                end else if (roll < push_w + pop_w + read_w) begin
                    op  = OP_READ;
                    cur = held(cap_in_use());
                    // Mostly good offsets, with the odd one at or past the count.
                    if (cur > 0 && $urandom_range(7) != 0) off = OFF_W'($urandom_range(cur - 1));
                    else if ($urandom_range(1) == 0) off = OFF_W'(cur);
                end else begin
                    op = OP_CLEAR;
                end
                send_request(op, d, off, 1'b0, '0);
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("Checked %0d requests over %0d capacity settings, deepest fill %0d.",
                 n_requests, n_settings, deepest);
        $display("Seen %0d overwriting pushes, %0d pops taken, %0d rejected reads.",
                 n_overwrite, n_popped, n_bad_read);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
